FILE: rtl/slt_pkg.sv
// Shared types, constants and helpers for the sorted list table.
package slt_pkg;

	localparam int CAPACITY      = 16;
	localparam int VALUE_WIDTH   = 32;
	localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int COUNT_FIELD_W = 5;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [CNT_W-1:0]              cnt_t;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2,
		STATUS_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic                     is_empty_flag;
		status_t                  status;
	} rsp_t;

	// Result of the shared comparator: entry against operand.
	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_res_t;

	// Memory port controls from the sequencer.
	typedef struct packed {
		logic   we;
		addr_t  waddr;
		value_t wdata;
		logic   re;
		addr_t  raddr;
	} ram_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CMP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DONE
	} fsm_state_t;

	function automatic value_t to_value(logic signed [31:0] v);
		return VALUE_WIDTH'(v);
	endfunction

	function automatic logic [COUNT_FIELD_W-1:0] count_field(cnt_t n);
		return COUNT_FIELD_W'(n);
	endfunction

endpackage

FILE: rtl/sorted_list_table.sv
// Top level of the sorted list table: sequencer, comparator and entry store.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  func, value
//   rsp      out        rsp_valid / rsp_stall  found, entry_count, is_empty_flag, status
//
// A request passes through ST_IDLE, ST_DISPATCH and ST_DONE, and each entry
// visited takes a read state and a compare or write state; a final read state
// ends an insert that reaches slot zero, a scan that runs past the last entry
// and a delete's move. Insert shifts the entries at or above the value up from
// the top, delete and lookup scan from the bottom, and delete then moves the
// remaining entries down. The single read port of the entry store sets this.
// Reset clears the count and the control state; entries are never read above it.
// A result waits in the output register while rsp_stall is high; the next
// request is taken once the previous result has been loaded.
module sorted_list_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  slt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output slt_pkg::rsp_t  rsp
);
	slt_pkg::ram_ctl_t ram_ctl;
	slt_pkg::value_t   ram_rdata;
	slt_pkg::value_t   cmp_entry;
	slt_pkg::value_t   cmp_operand;
	slt_pkg::cmp_res_t cmp_res;

	slt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.ram_ctl     (ram_ctl),
		.ram_rdata   (ram_rdata),
		.cmp_entry   (cmp_entry),
		.cmp_operand (cmp_operand),
		.cmp_res     (cmp_res)
	);

	slt_cmp u_cmp (
		.entry   (cmp_entry),
		.operand (cmp_operand),
		.res     (cmp_res)
	);

	slt_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.rdata (ram_rdata)
	);
endmodule

FILE: rtl/slt_ram.sv
// Entry store: one write port, one registered read port.
module slt_ram (
	input  logic              clk,
	input  slt_pkg::ram_ctl_t ctl,
	output slt_pkg::value_t   rdata
);
	slt_pkg::value_t mem [slt_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[ctl.raddr];
		end
	end
endmodule

FILE: rtl/slt_cmp.sv
// Shared signed comparator used by every scan step.
module slt_cmp (
	input  slt_pkg::value_t   entry,
	input  slt_pkg::value_t   operand,
	output slt_pkg::cmp_res_t res
);
	assign res.ge = (entry >= operand);
	assign res.eq = (entry == operand);
endmodule

FILE: rtl/slt_ctrl.sv
// Sequencer that walks the table one entry per step for each request.
module slt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  slt_pkg::req_t     req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output slt_pkg::rsp_t     rsp,
	output slt_pkg::ram_ctl_t ram_ctl,
	input  slt_pkg::value_t   ram_rdata,
	output slt_pkg::value_t   cmp_entry,
	output slt_pkg::value_t   cmp_operand,
	input  slt_pkg::cmp_res_t cmp_res
);
	slt_pkg::fsm_state_t state_q, state_d;
	slt_pkg::func_t      func_q;
	slt_pkg::value_t     v_q;
	slt_pkg::cnt_t       n_q;
	slt_pkg::cnt_t       idx_q;
	slt_pkg::status_t    status_q;
	logic                found_q;
	slt_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;

	slt_pkg::cnt_t idx_dec;
	slt_pkg::cnt_t idx_inc;
	logic          accept;
	logic          out_free;

	assign idx_dec  = idx_q - 1'b1;
	assign idx_inc  = idx_q + 1'b1;
	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign cmp_entry   = ram_rdata;
	assign cmp_operand = v_q;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			slt_pkg::ST_IDLE: begin
				if (accept) state_d = slt_pkg::ST_DISPATCH;
			end
			slt_pkg::ST_DISPATCH: begin
				case (func_q)
					slt_pkg::FUNC_INSERT: begin
						state_d = (n_q >= slt_pkg::CNT_W'(slt_pkg::CAPACITY)) ?
							slt_pkg::ST_DONE : slt_pkg::ST_INS_RD;
					end
					slt_pkg::FUNC_DELETE, slt_pkg::FUNC_LOOKUP: begin
						state_d = (n_q == '0) ? slt_pkg::ST_DONE : slt_pkg::ST_SRCH_RD;
					end
					default: state_d = slt_pkg::ST_DONE;
				endcase
			end
			slt_pkg::ST_INS_RD: begin
				state_d = (idx_q == '0) ? slt_pkg::ST_DONE : slt_pkg::ST_INS_CMP;
			end
			slt_pkg::ST_INS_CMP: begin
				state_d = cmp_res.ge ? slt_pkg::ST_INS_RD : slt_pkg::ST_DONE;
			end
			slt_pkg::ST_SRCH_RD: begin
				state_d = (idx_q == n_q) ? slt_pkg::ST_DONE : slt_pkg::ST_SRCH_CMP;
			end
			slt_pkg::ST_SRCH_CMP: begin
				if (cmp_res.eq) begin
					state_d = (func_q == slt_pkg::FUNC_DELETE) ?
						slt_pkg::ST_DEL_RD : slt_pkg::ST_DONE;
				end else begin
					state_d = slt_pkg::ST_SRCH_RD;
				end
			end
			slt_pkg::ST_DEL_RD: begin
				state_d = (idx_inc >= n_q) ? slt_pkg::ST_DONE : slt_pkg::ST_DEL_WR;
			end
			slt_pkg::ST_DEL_WR: state_d = slt_pkg::ST_DEL_RD;
			slt_pkg::ST_DONE: begin
				if (out_free) state_d = slt_pkg::ST_IDLE;
			end
			default: state_d = slt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall     = (state_q != slt_pkg::ST_IDLE);
		ram_ctl.we    = 1'b0;
		ram_ctl.waddr = idx_q[slt_pkg::ADDR_W-1:0];
		ram_ctl.wdata = v_q;
		ram_ctl.re    = 1'b0;
		ram_ctl.raddr = idx_q[slt_pkg::ADDR_W-1:0];
		case (state_q)
			slt_pkg::ST_INS_RD: begin
				// At the bottom of the table the new value lands at slot zero.
				if (idx_q == '0) begin
					ram_ctl.we = 1'b1;
				end else begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = idx_dec[slt_pkg::ADDR_W-1:0];
				end
			end
			slt_pkg::ST_INS_CMP: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.wdata = cmp_res.ge ? ram_rdata : v_q;
			end
			slt_pkg::ST_SRCH_RD: begin
				ram_ctl.re = (idx_q != n_q);
			end
			slt_pkg::ST_DEL_RD: begin
				ram_ctl.re    = (idx_inc < n_q);
				ram_ctl.raddr = idx_inc[slt_pkg::ADDR_W-1:0];
			end
			slt_pkg::ST_DEL_WR: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slt_pkg::ST_IDLE;
			n_q         <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == slt_pkg::ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				slt_pkg::ST_DISPATCH: begin
					case (func_q)
						slt_pkg::FUNC_INSERT: idx_q <= n_q;
						slt_pkg::FUNC_CLEAR:  n_q   <= '0;
						default:              idx_q <= '0;
					endcase
				end
				slt_pkg::ST_INS_RD: begin
					if (idx_q == '0) n_q <= n_q + 1'b1;
				end
				slt_pkg::ST_INS_CMP: begin
					if (cmp_res.ge) begin
						idx_q <= idx_dec;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				slt_pkg::ST_SRCH_CMP: begin
					if (!cmp_res.eq) idx_q <= idx_inc;
				end
				slt_pkg::ST_DEL_RD: begin
					if (idx_inc >= n_q) n_q <= n_q - 1'b1;
				end
				slt_pkg::ST_DEL_WR: idx_q <= idx_inc;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			v_q      <= slt_pkg::to_value(req.value);
			found_q  <= 1'b0;
			status_q <= slt_pkg::STATUS_OK;
		end
		case (state_q)
			slt_pkg::ST_DISPATCH: begin
				if (func_q == slt_pkg::FUNC_INSERT &&
						n_q >= slt_pkg::CNT_W'(slt_pkg::CAPACITY)) begin
					status_q <= slt_pkg::STATUS_FULL;
				end
				if ((func_q == slt_pkg::FUNC_DELETE || func_q == slt_pkg::FUNC_LOOKUP) &&
						n_q == '0) begin
					status_q <= slt_pkg::STATUS_EMPTY;
				end
			end
			slt_pkg::ST_SRCH_RD: begin
				if (idx_q == n_q) status_q <= slt_pkg::STATUS_NOT_FOUND;
			end
			slt_pkg::ST_SRCH_CMP: begin
				if (cmp_res.eq) found_q <= 1'b1;
			end
			slt_pkg::ST_DONE: begin
				if (out_free) begin
					rsp_q.found         <= found_q;
					rsp_q.entry_count   <= slt_pkg::count_field(n_q);
					rsp_q.is_empty_flag <= (n_q == '0);
					rsp_q.status        <= status_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

FILE: verif/tb.sv
// Testbench for the sorted list table: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int ITEMS_PER_PHASE = 210;

	// Predicts the result word of every accepted request and checks the words that come back.
	class sorted_table_predictor;
		slt_pkg::value_t entries[slt_pkg::CAPACITY];
		int held;
		slt_pkg::rsp_t pending_rsps[$];
		int mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		function int pending();
			return pending_rsps.size();
		endfunction

		function slt_pkg::value_t pick_held();
			return entries[$urandom_range(0, held - 1)];
		endfunction

		function void take_request(slt_pkg::req_t item);
			slt_pkg::rsp_t exp_rsp;
			slt_pkg::value_t v;
			int pos;
			int i;
			v = slt_pkg::value_t'(item.value);
			exp_rsp.found = 1'b0;
			exp_rsp.status = slt_pkg::STATUS_OK;
			case (item.func)
				slt_pkg::FUNC_INSERT: begin
					if (held >= slt_pkg::CAPACITY) begin
						exp_rsp.status = slt_pkg::STATUS_FULL;
					end else begin
						// The new entry goes ahead of any equal entries.
						pos = held;
						for (i = 0; i < held; i++)
							if (entries[i] >= v) begin
								pos = i;
								break;
							end
						for (i = held; i > pos; i--)
							entries[i] = entries[i - 1];
						entries[pos] = v;
						held++;
					end
				end
				slt_pkg::FUNC_DELETE, slt_pkg::FUNC_LOOKUP: begin
					if (held == 0) begin
						exp_rsp.status = slt_pkg::STATUS_EMPTY;
					end else begin
						pos = held;
						for (i = 0; i < held; i++)
							if (entries[i] == v) begin
								pos = i;
								break;
							end
						if (pos == held) begin
							exp_rsp.status = slt_pkg::STATUS_NOT_FOUND;
						end else begin
							exp_rsp.found = 1'b1;
							if (item.func == slt_pkg::FUNC_DELETE) begin
								for (i = pos; i + 1 < held; i++)
									entries[i] = entries[i + 1];
								held--;
							end
						end
					end
				end
				default: begin
					held = 0;
				end
			endcase
			exp_rsp.entry_count = slt_pkg::COUNT_FIELD_W'(held);
			exp_rsp.is_empty_flag = (held == 0);
			pending_rsps.push_back(exp_rsp);
		endfunction

		task check_rsp(slt_pkg::rsp_t got);
			slt_pkg::rsp_t exp_rsp;
			if (pending_rsps.size() == 0) begin
				report_mismatch($sformatf("word %h arrived with nothing expected", got));
				return;
			end
			exp_rsp = pending_rsps.pop_front();
			if (got.found !== exp_rsp.found)
				report_mismatch($sformatf("found %b, expected %b", got.found, exp_rsp.found));
			if (got.entry_count !== exp_rsp.entry_count)
				report_mismatch($sformatf("entry_count %0d, expected %0d",
					got.entry_count, exp_rsp.entry_count));
			if (got.is_empty_flag !== exp_rsp.is_empty_flag)
				report_mismatch($sformatf("is_empty_flag %b, expected %b",
					got.is_empty_flag, exp_rsp.is_empty_flag));
			if (got.status !== exp_rsp.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, exp_rsp.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	slt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	slt_pkg::rsp_t rsp;

	int send_idle_pct = 18;
	int rcv_idle_pct = 68;
	int hold_asked = 0;

	sorted_table_predictor sb = new();

	sorted_list_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Response side: checks each accepted word, then picks the stall for the next cycle.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_rsp(rsp);
			if (holds_seen != hold_asked) begin
				holds_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	// Ends the run when no word moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet);
				$display("** sorted_list_table: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_req(input slt_pkg::func_t f, input logic signed [31:0] v);
		int gap;
		slt_pkg::req_t item;
		gap = 0;
		item.func = f;
		item.value = v;
		while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.take_request(item);
	endtask

	// Stops offering words until every expected result has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_value(bit for_insert);
		int r;
		r = $urandom_range(0, 99);
		if (sb.held > 0 && r < (for_insert ? 15 : 60))
			return sb.pick_held();
		r = $urandom_range(0, 99);
		if (r < 40)
			return 32'($urandom_range(0, 8)) - 32'd4;
		if (r < 60) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				3: return 32'hffff_ffff;
				4: return 32'h8000_0001;
				default: return 32'h7fff_fffe;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_random(int ins_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			send_req(slt_pkg::FUNC_CLEAR, $urandom);
		else if (r < 3 + ins_pct)
			send_req(slt_pkg::FUNC_INSERT, pick_value(1'b1));
		else if ($urandom_range(0, 1))
			send_req(slt_pkg::FUNC_DELETE, pick_value(1'b0));
		else
			send_req(slt_pkg::FUNC_LOOKUP, pick_value(1'b0));
	endtask

	initial begin
		int ph;
		int n;
		int k;
		int fill_len;
		int ins_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, extremes, head of table, equal values and clears.
		send_req(slt_pkg::FUNC_CLEAR, 32'h1234_5678);
		send_req(slt_pkg::FUNC_LOOKUP, 32'd5);
		send_req(slt_pkg::FUNC_DELETE, 32'd5);
		send_req(slt_pkg::FUNC_INSERT, 32'd0);
		send_req(slt_pkg::FUNC_INSERT, 32'h7fff_ffff);
		send_req(slt_pkg::FUNC_INSERT, 32'h8000_0000);
		send_req(slt_pkg::FUNC_INSERT, 32'hffff_ffff);
		send_req(slt_pkg::FUNC_INSERT, 32'd0);
		send_req(slt_pkg::FUNC_LOOKUP, 32'd0);
		send_req(slt_pkg::FUNC_LOOKUP, 32'd7);
		send_req(slt_pkg::FUNC_DELETE, 32'd7);
		send_req(slt_pkg::FUNC_DELETE, 32'h8000_0000);
		send_req(slt_pkg::FUNC_DELETE, 32'h7fff_ffff);
		send_req(slt_pkg::FUNC_DELETE, 32'd0);
		send_req(slt_pkg::FUNC_LOOKUP, 32'd0);
		send_req(slt_pkg::FUNC_DELETE, 32'hffff_ffff);
		send_req(slt_pkg::FUNC_CLEAR, 32'hffff_ffff);
		send_req(slt_pkg::FUNC_CLEAR, 32'h0000_0000);
		wait_drained();

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 18;
					rcv_idle_pct <= 68;
				end
				1: begin
					send_idle_pct = 68;
					rcv_idle_pct <= 18;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct <= 0;
					// The receiver holds off while words keep coming, so the input backs up.
					hold_asked <= hold_asked + 1;
				end
			endcase
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				case ($urandom_range(0, 3))
					0: begin
						// Fill from empty up to or past capacity so that inserts may get refused.
						fill_len = $urandom_range(16, 20);
						send_req(slt_pkg::FUNC_CLEAR, $urandom);
						for (k = 0; k < fill_len; k++)
							send_req(slt_pkg::FUNC_INSERT, pick_value(1'b1));
						n += fill_len + 1;
					end
					default: begin
						ins_pct = (sb.held > 10) ? 25 : ((sb.held < 4) ? 70 : 45);
						for (k = 0; k < 20; k++)
							send_random(ins_pct);
						n += 20;
					end
				endcase
			end
			wait_drained();
		end

		repeat (60) @(posedge clk);
		if (sb.mismatches == 0)
			$display("** sorted_list_table: PASSED **");
		else
			$display("** sorted_list_table: FAILED **");
		$finish;
	end

endmodule
